// ===== rtl/core/llfl_pkg.sv =====
package llfl_pkg;

  localparam int OUT_IDX_BITS = 6;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_SLOT   = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    clear;
    logic    add_rd;
    logic    add_take;
    logic    add_link;
    logic    walk_start;
    logic    walk_adv;
    logic    found;
    logic    unlink;
    logic    free_push;
    logic    res_plain;
    status_t res_code;
    logic    emit;
  } ctrl_t;

  typedef struct packed {
    logic head_nil;
    logic free_nil;
    logic key_match;
    logic walk_end;
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/core/llfl_req_if.sv =====
interface llfl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] key;

  modport source (output valid, command, key, input ready);
  modport sink (input valid, command, key, output ready);
endinterface

// ===== rtl/core/llfl_rsp_if.sv =====
interface llfl_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       slot_valid;
  logic [5:0] slot_index;
  logic       prev_valid;
  logic [5:0] prev_index;

  modport source (output valid, status, slot_valid, slot_index, prev_valid, prev_index,
                  input ready);
  modport sink (input valid, status, slot_valid, slot_index, prev_valid, prev_index,
                output ready);
endinterface

// ===== rtl/core/llfl_datapath.sv =====
module llfl_datapath #(
  parameter int NODES    = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  llfl_pkg::ctrl_t               ctl,
  output llfl_pkg::stat_t               stat,
  input  logic [31:0]                   req_key,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [1:0]                    rsp_status,
  output logic                          rsp_slot_valid,
  output logic [llfl_pkg::OUT_IDX_BITS-1:0] rsp_slot_index,
  output logic                          rsp_prev_valid,
  output logic [llfl_pkg::OUT_IDX_BITS-1:0] rsp_prev_index
);
  import llfl_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int IW = $clog2(NODES + 1);

  typedef logic [IW-1:0] idx_t;

  localparam idx_t NIL  = idx_t'(NODES);
  localparam idx_t LAST = idx_t'(NODES - 1);

  idx_t                link_mem [NODES];
  logic [KEY_BITS-1:0] key_mem  [NODES];

  idx_t                head;
  idx_t                tail;
  idx_t                free_head;
  idx_t                hwm;
  idx_t                cur;
  idx_t                prev;
  idx_t                steps;
  logic [KEY_BITS-1:0] key_r;
  idx_t                link_q;
  logic [KEY_BITS-1:0] key_q;
  logic                fresh_q;
  idx_t                fresh_link_q;
  logic [1:0]          res_status;
  idx_t                res_slot;
  idx_t                res_prev;

  logic                rd_en;
  idx_t                rd_addr;
  logic                wr_en;
  idx_t                wr_addr;
  idx_t                wr_data;
  idx_t                link_out;
  logic                list_empty;
  logic [KEY_BITS+31:0] key_wide;

  function automatic logic [OUT_IDX_BITS-1:0] low_idx(idx_t v);
    logic [IW+OUT_IDX_BITS-1:0] w;
    w = {{OUT_IDX_BITS{1'b0}}, v};
    return (v == NIL) ? '0 : w[OUT_IDX_BITS-1:0];
  endfunction

  // slots at or above the fill mark read their link as the next slot (NIL for the last), not from memory
  assign link_out   = fresh_q ? fresh_link_q : link_q;
  assign list_empty = (head == NIL) || (tail == NIL);
  assign key_wide   = {{KEY_BITS{1'b0}}, req_key};

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = free_head;
    if (ctl.add_rd) begin
      rd_en   = 1'b1;
      rd_addr = free_head;
    end else if (ctl.walk_start) begin
      rd_en   = 1'b1;
      rd_addr = head;
    end else if (ctl.walk_adv) begin
      rd_en   = 1'b1;
      rd_addr = link_out;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = NIL;
    if (ctl.add_take) begin
      wr_en   = 1'b1;
      wr_addr = cur;
      wr_data = NIL;
    end else if (ctl.add_link && !list_empty) begin
      wr_en   = 1'b1;
      wr_addr = tail;
      wr_data = cur;
    end else if (ctl.unlink && prev != NIL) begin
      wr_en   = 1'b1;
      wr_addr = prev;
      wr_data = link_out;
    end else if (ctl.free_push) begin
      wr_en   = 1'b1;
      wr_addr = cur;
      wr_data = free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (ctl.add_take) begin
      key_mem[cur[AW-1:0]] <= key_r;
    end
    if (rd_en) begin
      link_q       <= link_mem[rd_addr[AW-1:0]];
      key_q        <= key_mem[rd_addr[AW-1:0]];
      fresh_q      <= (rd_addr >= hwm);
      fresh_link_q <= (rd_addr == LAST) ? NIL : rd_addr + idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= key_wide[KEY_BITS-1:0];
    end
    if (ctl.add_rd) begin
      cur <= free_head;
    end
    if (ctl.walk_start) begin
      cur   <= head;
      prev  <= NIL;
      steps <= idx_t'(1);
    end
    if (ctl.walk_adv) begin
      prev  <= cur;
      cur   <= link_out;
      steps <= steps + idx_t'(1);
    end
    if (ctl.res_plain) begin
      res_status <= ctl.res_code;
      res_slot   <= NIL;
      res_prev   <= NIL;
    end else if (ctl.found) begin
      res_status <= ST_OK;
      res_slot   <= cur;
      res_prev   <= prev;
    end else if (ctl.add_link) begin
      res_status <= ST_OK;
      res_slot   <= cur;
      res_prev   <= list_empty ? NIL : tail;
    end
    if (ctl.emit) begin
      rsp_status     <= res_status;
      rsp_slot_valid <= (res_slot != NIL);
      rsp_slot_index <= low_idx(res_slot);
      rsp_prev_valid <= (res_prev != NIL);
      rsp_prev_index <= low_idx(res_prev);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      head      <= NIL;
      tail      <= NIL;
      free_head <= '0;
      hwm       <= '0;
    end else begin
      if (ctl.add_take) begin
        free_head <= link_out;
        if (cur == hwm) begin
          hwm <= hwm + idx_t'(1);
        end
      end
      if (ctl.add_link) begin
        if (list_empty) begin
          head <= cur;
        end
        tail <= cur;
      end
      if (ctl.unlink) begin
        if (prev == NIL) begin
          head <= link_out;
          if (link_out == NIL) begin
            tail <= NIL;
          end
        end else if (cur == tail) begin
          tail <= prev;
        end
      end
      if (ctl.free_push) begin
        free_head <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign stat.head_nil  = (head == NIL);
  assign stat.free_nil  = (free_head == NIL);
  assign stat.key_match = (key_q == key_r);
  assign stat.walk_end  = (link_out == NIL) || (steps == NIL);
  assign stat.out_busy  = rsp_valid && !rsp_ready;

endmodule

// ===== rtl/core/llfl_ctrl.sv =====
module llfl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  logic [1:0]      req_command,
  input  llfl_pkg::stat_t stat,
  output llfl_pkg::ctrl_t ctl
);
  import llfl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_TAKE,
    S_ADD_LINK,
    S_START,
    S_WALK,
    S_FREE,
    S_EMIT
  } state_t;

  state_t   state;
  state_t   state_next;
  command_t op;
  command_t req_op;

  assign req_op    = command_t'(req_command);
  assign req_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    ctl.res_code = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.load = 1'b1;
          unique case (req_op)
            CMD_ADD: state_next = S_ADD_RD;
            CMD_FIND, CMD_REMOVE: state_next = S_START;
            CMD_CLEAR: begin
              ctl.clear     = 1'b1;
              ctl.res_plain = 1'b1;
              ctl.res_code  = ST_OK;
              state_next    = S_EMIT;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: begin
        if (stat.free_nil) begin
          ctl.res_plain = 1'b1;
          ctl.res_code  = ST_NO_SLOT;
          state_next    = S_EMIT;
        end else begin
          ctl.add_rd = 1'b1;
          state_next = S_ADD_TAKE;
        end
      end
      S_ADD_TAKE: begin
        ctl.add_take = 1'b1;
        state_next   = S_ADD_LINK;
      end
      S_ADD_LINK: begin
        ctl.add_link = 1'b1;
        state_next   = S_EMIT;
      end
      S_START: begin
        if (stat.head_nil) begin
          ctl.res_plain = 1'b1;
          ctl.res_code  = ST_NOT_FOUND;
          state_next    = S_EMIT;
        end else begin
          ctl.walk_start = 1'b1;
          state_next     = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.key_match) begin
          ctl.found = 1'b1;
          if (op == CMD_REMOVE) begin
            ctl.unlink = 1'b1;
            state_next = S_FREE;
          end else begin
            state_next = S_EMIT;
          end
        end else if (stat.walk_end) begin
          ctl.res_plain = 1'b1;
          ctl.res_code  = ST_NOT_FOUND;
          state_next    = S_EMIT;
        end else begin
          ctl.walk_adv = 1'b1;
        end
      end
      S_FREE: begin
        ctl.free_push = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= CMD_ADD;
    end else begin
      state <= state_next;
      if (state == S_IDLE && req_valid) begin
        op <= req_op;
      end
    end
  end

endmodule

// ===== rtl/core/linked_list_with_free_list.sv =====
// singly linked list of NODES slots with a free list of unused slots
// req channel: command (add, find, remove, clear) and key; one transfer per item
// rsp channel: status, slot and predecessor; exactly one transfer per request
// a request is taken only while the block is idle, one item at a time
// steps from request transfer to result on rsp:
//   add reads, takes and links a free slot, clear goes straight to the result,
//   find walks n list entries and remove also unlinks and frees the slot (n at most NODES)
// the search visits one entry per cycle, set by the single read port of the
// link and key memories
// the result sits in an output register; the next request is taken as soon
// as the result is loaded, and a stalled rsp only holds back the following
// result, which then waits until the register frees
// reset empties the list and puts every slot on the free chain without writing memory:
// a fill mark stands in for the untouched part of the chain, so no clearing
// pass is needed; clear does the same and keeps stored keys
module linked_list_with_free_list #(
  parameter int NODES    = 64,
  parameter int KEY_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  llfl_req_if.sink         req,
  llfl_rsp_if.source       rsp
);
  import llfl_pkg::*;

  ctrl_t ctl;
  stat_t stat;

  llfl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_command (req.command),
    .stat        (stat),
    .ctl         (ctl)
  );

  llfl_datapath #(
    .NODES    (NODES),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .req_key        (req.key),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_slot_valid (rsp.slot_valid),
    .rsp_slot_index (rsp.slot_index),
    .rsp_prev_valid (rsp.prev_valid),
    .rsp_prev_index (rsp.prev_index)
  );

endmodule
